FILE: rtl/pbl_pkg.sv
// Shared constants for the privacy button latch controller.
// Holds register reset values, register indexes and port widths; no dependencies.
`default_nettype none

package pbl_pkg;

	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int COUNT_WIDTH_DEF = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE_DELAY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 2'd3;

	// register values after reset, in ticks
	localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
	localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd3000;
	localparam logic [CFG_W-1:0] MUTE_DELAY_RST  = 16'd50;
	localparam logic [CFG_W-1:0] PULSE_RST       = 16'd1000;

endpackage

`default_nettype wire

FILE: rtl/privacy_button_latch_controller_core.sv
// Privacy button latch controller: debounce, press timing, mute delay and enable pulse.
// Depends on pbl_pkg for register indexes, reset values and widths.
`default_nettype none

// One request is one tick of the button, latch and software-engage lines, and
// yields one result with the enable level and the key and mute reports. The
// block takes one request per clock while the result is not stalled: a request
// is registered, all counters and flags are updated from it by compare/decrement
// logic, and the result is held in an output register, so throughput is one
// request per cycle when not stalled. A stalled result holds the input register,
// so the input stalls once both registers are full. Timer registers are loaded
// with their configured value clamped to 1..2^COUNT_WIDTH-1.
// Write configuration only while no request is in flight.
module privacy_button_latch_controller_core
	import pbl_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 button_level,
	input  wire logic                 latch_level,
	input  wire logic                 soft_engage,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      enable_drive,
	output logic                      key_level,
	output logic                      key_event,
	output logic                      mute_level,
	output logic                      mute_event,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};
	localparam logic [LW-1:0]          CNT_MAX_X = LW'(CNT_MAX);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t clamp_load(input logic [CFG_W-1:0] v);
		logic [LW-1:0] vx;
		vx = LW'(v);
		if (vx > CNT_MAX_X) vx = CNT_MAX_X;
		if (vx == '0) vx = LW'(1);
		return vx[COUNT_WIDTH-1:0];
	endfunction

	// configuration registers
	logic [CFG_W-1:0] debounce_q, short_press_q, mute_delay_q, pulse_q;

	// input stage
	logic valid_s1, button_s1, latch_s1, soft_s1;

	// block state
	logic last_raw_q, deb_armed_q, key_pressed_q, engage_armed_q;
	logic mute_armed_q, pulse_pending_q, reported_latch_q, reported_once_q;
	cnt_t deb_count_q, press_elapsed_q, mute_count_q, pulse_count_q;

	// next state
	logic last_raw_d, deb_armed_d, key_pressed_d, engage_armed_d;
	logic mute_armed_d, pulse_pending_d, reported_latch_d, reported_once_d;
	cnt_t deb_count_d, press_elapsed_d, mute_count_d, pulse_count_d;
	logic key_event_d, mute_event_d, mute_fire;
	cnt_t deb_load, mute_load, pulse_load;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	assign deb_load   = clamp_load(debounce_q);
	assign mute_load  = clamp_load(mute_delay_q);
	assign pulse_load = clamp_load(pulse_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			short_press_q <= SHORT_PRESS_RST;
			mute_delay_q  <= MUTE_DELAY_RST;
			pulse_q       <= PULSE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:    debounce_q    <= cfg_data;
				REG_SHORT_PRESS: short_press_q <= cfg_data;
				REG_MUTE_DELAY:  mute_delay_q  <= cfg_data;
				REG_PULSE:       pulse_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			button_s1 <= button_level;
			latch_s1  <= latch_level;
			soft_s1   <= soft_engage;
		end
	end

	always_comb begin
		press_elapsed_d  = press_elapsed_q;
		pulse_count_d    = pulse_count_q;
		pulse_pending_d  = pulse_pending_q;
		mute_count_d     = mute_count_q;
		mute_armed_d     = mute_armed_q;
		last_raw_d       = last_raw_q;
		deb_count_d      = deb_count_q;
		deb_armed_d      = deb_armed_q;
		key_pressed_d    = key_pressed_q;
		engage_armed_d   = engage_armed_q;
		reported_latch_d = reported_latch_q;
		reported_once_d  = reported_once_q;
		key_event_d      = 1'b0;
		mute_event_d     = 1'b0;
		mute_fire        = 1'b0;

		if (key_pressed_q && press_elapsed_q != CNT_MAX)
			press_elapsed_d = press_elapsed_q + cnt_t'(1);

		if (pulse_count_q != '0) pulse_count_d = pulse_count_q - cnt_t'(1);
		if (pulse_count_d == '0 && pulse_pending_q) begin
			pulse_count_d   = pulse_load;
			pulse_pending_d = 1'b0;
		end

		if (mute_armed_q) begin
			if (mute_count_q != '0) mute_count_d = mute_count_q - cnt_t'(1);
			if (mute_count_d == '0) begin
				mute_armed_d = 1'b0;
				mute_fire    = 1'b1;
			end
		end

		if (button_s1 != last_raw_q) begin
			last_raw_d  = button_s1;
			deb_count_d = deb_load;
			deb_armed_d = 1'b1;
		end else if (deb_armed_q) begin
			if (deb_count_q != '0) deb_count_d = deb_count_q - cnt_t'(1);
			if (deb_count_d == '0) begin
				deb_armed_d = 1'b0;
				if (button_s1 != key_pressed_q) begin
					key_pressed_d = button_s1;
					key_event_d   = 1'b1;
					if (button_s1) begin
						press_elapsed_d = '0;
						engage_armed_d  = !latch_s1;
					end else begin
						// short press that started with the latch off
						if (engage_armed_q && (LW'(press_elapsed_d) < LW'(short_press_q))) begin
							mute_count_d = mute_load;
							mute_armed_d = 1'b1;
						end
						engage_armed_d = 1'b0;
					end
				end
			end
		end

		// first request starts an idle pulse, any other request goes pending
		if (soft_s1 || mute_fire) begin
			if (pulse_count_d == '0) begin
				pulse_count_d = pulse_load;
				if (soft_s1 && mute_fire) pulse_pending_d = 1'b1;
			end else begin
				pulse_pending_d = 1'b1;
			end
		end

		if (!reported_once_q || latch_s1 != reported_latch_q) begin
			mute_event_d     = 1'b1;
			reported_latch_d = latch_s1;
			reported_once_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q       <= 1'b0;
			deb_count_q      <= '0;
			deb_armed_q      <= 1'b0;
			key_pressed_q    <= 1'b0;
			engage_armed_q   <= 1'b0;
			press_elapsed_q  <= '0;
			mute_count_q     <= '0;
			mute_armed_q     <= 1'b0;
			pulse_count_q    <= '0;
			pulse_pending_q  <= 1'b0;
			reported_latch_q <= 1'b0;
			reported_once_q  <= 1'b0;
		end else if (advance) begin
			last_raw_q       <= last_raw_d;
			deb_count_q      <= deb_count_d;
			deb_armed_q      <= deb_armed_d;
			key_pressed_q    <= key_pressed_d;
			engage_armed_q   <= engage_armed_d;
			press_elapsed_q  <= press_elapsed_d;
			mute_count_q     <= mute_count_d;
			mute_armed_q     <= mute_armed_d;
			pulse_count_q    <= pulse_count_d;
			pulse_pending_q  <= pulse_pending_d;
			reported_latch_q <= reported_latch_d;
			reported_once_q  <= reported_once_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_drive <= (pulse_count_d != '0);
			key_level    <= key_pressed_d;
			key_event    <= key_event_d;
			mute_level   <= reported_latch_d;
			mute_event   <= mute_event_d;
		end
	end

endmodule

`default_nettype wire
